// ----- rtl/core/skt_pkg.sv -----
// skt_pkg: shared types, widths and codes of the sorted key table.
// Used by every module under rtl/core; depends on nothing.
package skt_pkg;

    localparam int SKT_DEPTH = 64;

    localparam int KEY_W    = 32;
    localparam int SCORE_W  = 15;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [SCORE_W-1:0]      score;
    } t_rec;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

// ----- rtl/core/skt_mem.sv -----
// skt_mem: record store, one write port and one registered read port.
// Depends on skt_pkg for the record type.
module skt_mem #(
    parameter int DEPTH = skt_pkg::SKT_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output skt_pkg::t_rec o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  skt_pkg::t_rec i_wr_data
);
    import skt_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/skt_cmp.sv -----
// skt_cmp: shared signed key comparator used by the search loop.
// Depends on skt_pkg for key width and the compare result type.
module skt_cmp (
    input  logic signed [skt_pkg::KEY_W-1:0] i_stored,
    input  logic signed [skt_pkg::KEY_W-1:0] i_probe,
    output skt_pkg::t_cmp                    o_cmp
);
    import skt_pkg::*;

    always_comb begin
        o_cmp.lt = (i_stored < i_probe);
        o_cmp.eq = (i_stored == i_probe);
    end

endmodule

// ----- rtl/core/skt_seq.sv -----
// skt_seq: sequencer for search, shift and place; holds the record count.
// Depends on skt_pkg; drives skt_mem and reads the skt_cmp result.
module skt_seq #(
    parameter int DEPTH = skt_pkg::SKT_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic signed [skt_pkg::KEY_W-1:0]    i_key,
    input  logic [skt_pkg::SCORE_W-1:0]         i_score,
    output logic                                o_done,
    output logic [skt_pkg::STATUS_W-1:0]        o_status,
    output logic [skt_pkg::COUNT_W-1:0]         o_record_count,
    output logic signed [skt_pkg::KEY_W-1:0]    o_probe,
    input  skt_pkg::t_cmp                       i_cmp,
    output logic                                o_rd_en,
    output logic [AW-1:0]                       o_rd_addr,
    input  skt_pkg::t_rec                       i_rd_data,
    output logic                                o_wr_en,
    output logic [AW-1:0]                       o_wr_addr,
    output skt_pkg::t_rec                       o_wr_data
);
    import skt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHUP   = 3'd3;
    localparam logic [2:0] S_PLACE  = 3'd4;
    localparam logic [2:0] S_SHDN   = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [AW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_pos, n_pos;
    logic                    r_found, n_found;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_done, n_done;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic                    r_func, n_func;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [SCORE_W-1:0]      r_score, n_score;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_found   = r_found;
        n_count   = r_count;
        n_done    = 1'b0;
        n_status  = r_status;
        n_func    = r_func;
        n_key     = r_key;
        n_score   = r_score;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = '{key: r_key, score: r_score};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func  = i_func;
                    n_key   = i_key;
                    n_score = i_score;
                    n_idx   = '0;
                    if (r_count == '0) begin
                        n_pos   = '0;
                        n_found = 1'b0;
                        n_state = S_DECIDE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = '0;
                        n_state   = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // first stored key not below the probe ends the scan
                if (!i_cmp.lt) begin
                    n_pos   = CW'(r_idx);
                    n_found = i_cmp.eq;
                    n_state = S_DECIDE;
                end else if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_pos   = r_count;
                    n_found = 1'b0;
                    n_state = S_DECIDE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end
            S_DECIDE: begin
                if (r_func == FUNC_INSERT) begin
                    if (r_found) begin
                        n_done   = 1'b1;
                        n_status = ST_DUPLICATE;
                        n_state  = S_IDLE;
                    end else if (r_count == CW'(DEPTH)) begin
                        n_done   = 1'b1;
                        n_status = ST_FULL;
                        n_state  = S_IDLE;
                    end else if (r_pos == r_count) begin
                        // append at the tail, nothing to move
                        o_wr_en   = 1'b1;
                        o_wr_addr = AW'(r_pos);
                        n_count   = r_count + CW'(1);
                        n_done    = 1'b1;
                        n_status  = ST_INSERTED;
                        n_state   = S_IDLE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = AW'(r_count - CW'(1));
                        n_idx     = AW'(r_count - CW'(1));
                        n_state   = S_SHUP;
                    end
                end else begin
                    if (!r_found) begin
                        n_done   = 1'b1;
                        n_status = ST_NOT_FOUND;
                        n_state  = S_IDLE;
                    end else if (r_pos + CW'(1) == r_count) begin
                        // last record: drop it by shrinking the count
                        n_count  = r_count - CW'(1);
                        n_done   = 1'b1;
                        n_status = ST_DELETED;
                        n_state  = S_IDLE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = AW'(r_pos + CW'(1));
                        n_idx     = AW'(r_pos + CW'(1));
                        n_state   = S_SHDN;
                    end
                end
            end
            S_SHUP: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx + AW'(1);
                o_wr_data = i_rd_data;
                if (CW'(r_idx) == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx - AW'(1);
                    n_idx     = r_idx - AW'(1);
                end
            end
            S_PLACE: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_pos);
                n_count   = r_count + CW'(1);
                n_done    = 1'b1;
                n_status  = ST_INSERTED;
                n_state   = S_IDLE;
            end
            S_SHDN: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx - AW'(1);
                o_wr_data = i_rd_data;
                if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_count  = r_count - CW'(1);
                    n_done   = 1'b1;
                    n_status = ST_DELETED;
                    n_state  = S_IDLE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_status <= n_status;
        r_func   <= n_func;
        r_key    <= n_key;
        r_score  <= n_score;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_record_count = COUNT_W'(r_count);
    assign o_probe        = r_key;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("record count above table depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while sequencer active");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_wr_en)
        else $error("store written while idle");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == ST_INSERTED) |-> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_status == ST_DUPLICATE || r_status == ST_FULL
                    || r_status == ST_NOT_FOUND)) |-> $stable(r_count))
        else $error("rejected item changed the count");

endmodule

// ----- rtl/core/sorted_key_table_top.sv -----
// sorted_key_table_top: top level of the sorted key table.
// Depends on skt_pkg, skt_mem, skt_cmp and skt_seq.
//
// Usage:
//   Command channel: drive i_func, i_key and i_score and raise start; the
//   transfer happens at the clock edge where start is high and busy is low.
//   i_func selects insert (record placed in ascending signed key order) or
//   delete (record with a matching key removed).
//   Result channel: o_done pulses for exactly one cycle with o_status and
//   o_record_count. The receiver cannot stall; sample on the o_done cycle.
//   Busy drops in the same cycle that o_done is high, so a new command can
//   transfer while the previous result is still shown.
// Operation:
//   One item walks the table with a single comparator, one stored record per
//   cycle, then moves records one per cycle over the single read and write
//   port of the store. Busy stays high until the item is done, and o_done
//   rises at the edge where busy drops; a new command is not taken while
//   busy is high.
// Reset:
//   i_rst_n is synchronous, active low; it empties the table (count zero) and
//   idles the sequencer. Store contents are not cleared; only entries below
//   the count are ever read.
module sorted_key_table_top #(
    parameter int DEPTH = skt_pkg::SKT_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_func,
    input  logic signed [skt_pkg::KEY_W-1:0] i_key,
    input  logic [skt_pkg::SCORE_W-1:0]      i_score,
    output logic                             o_done,
    output logic [skt_pkg::STATUS_W-1:0]     o_status,
    output logic [skt_pkg::COUNT_W-1:0]      o_record_count
);
    import skt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // store access from the sequencer
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_rec          rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_rec          wr_data;

    // shared comparator: stored key from the read port against the probe
    logic signed [KEY_W-1:0] probe;
    t_cmp                    cmp;

    skt_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    skt_cmp u_cmp (
        .i_stored (rd_data.key),
        .i_probe  (probe),
        .o_cmp    (cmp)
    );

    skt_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_score        (i_score),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_record_count (o_record_count),
        .o_probe        (probe),
        .i_cmp          (cmp),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data)
    );

endmodule
